FILE: rtl/encoder_dimmer_with_auto_fade_defines.svh
// Assertion macros shared by the dimmer checker.
`ifndef ENCODER_DIMMER_WITH_AUTO_FADE_DEFINES_SVH
`define ENCODER_DIMMER_WITH_AUTO_FADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EDIM_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("dimmer check failed");

// Next-cycle implication, disabled while reset is asserted
`define EDIM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("dimmer check failed");

`endif

FILE: rtl/edim_pkg.sv
// Types and constants shared by the encoder dimmer modules.
package edim_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned GAIN_W    = 6;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned PWM_W     = 14;
    localparam int unsigned DIVISOR_W = LEVEL_W + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 8'hFF;
    localparam logic [LEVEL_W-1:0] REMEMBERED_INIT = 8'd255;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 6'd8;
    localparam logic [TIME_W-1:0]  FADE_TIME_RESET = 32'd3600000;

    // Configuration register indexes
    localparam logic CFG_STEP_GAIN    = 1'b0;
    localparam logic CFG_FADE_TIME_MS = 1'b1;

    // One control-loop pass
    typedef struct packed {
        logic signed [7:0]  encoder_count;
        logic               button_event;
        logic [TIME_W-1:0]  now_ms;
    } in_word_t;

    // One result
    typedef struct packed {
        logic [PWM_W-1:0]   pwm_compare;
        logic [LEVEL_W-1:0] brightness_level;
    } out_word_t;

    // Divider handshake
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

FILE: rtl/edim_div.sv
// Bit-serial restoring divider: 32-bit dividend by a 9-bit nonzero divisor.
module edim_div
    import edim_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TIME_W-1:0]      dividend,
    input  logic [DIVISOR_W-1:0]   divisor,
    output logic                   done,
    output logic [TIME_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(TIME_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]    quot_reg;
    logic [LEVEL_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;

    logic [DIVISOR_W-1:0] trial;
    logic [DIVISOR_W-1:0] diff;
    logic                 ge;
    logic [LEVEL_W-1:0]   rem_next;
    logic [TIME_W-1:0]    quot_next;

    // One quotient bit per cycle: shift in, trial subtract
    always_comb
    begin
        trial     = {rem_reg, quot_reg[TIME_W-1]};
        ge        = (trial >= divisor_reg);
        diff      = trial - divisor_reg;
        rem_next  = ge ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
        quot_next = {quot_reg[TIME_W-2:0], ge};
    end

    // Control: busy for TIME_W steps, done pulses after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/encoder_dimmer_with_auto_fade.sv
// Encoder dimmer top level: level update, fade timer and PWM compare.
// Usage:
//   item channel (item_valid / item_stall / item) carries one control-loop
//   pass: encoder count, button event and millisecond time. Each word yields
//   exactly one result word on the result channel (result_valid /
//   result_stall / result) with the PWM compare and the applied level.
//   A pass without user input goes through the calc, fade and output
//   steps; a pass with user input also runs the divider step, since the fade
//   interval is then recomputed by a bit-serial divider (one quotient bit per
//   cycle, 32 bits). item_stall is high while a word is in work, so only one
//   pass is processed at a time.
//   The result register decouples the two sides: a new word may be taken
//   while the previous result is still waiting. If the receiver stalls, the
//   finished pass waits in its last step and item_stall stays high.
//   Configuration (cfg_en / cfg_index / cfg_data) writes step_gain
//   (index 0) or fade_time_ms (index 1); write only while the block is idle.
//   A new fade time takes effect at the next user input.
//   Reset (rst_n low, asynchronous) clears levels to off, the remembered
//   level to full, and restores gain and fade time to their defaults.
module encoder_dimmer_with_auto_fade
    import edim_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  in_word_t          item,
    output logic              result_valid,
    input  logic              result_stall,
    output out_word_t         result,
    input  logic              cfg_en,
    input  logic              cfg_index,
    input  logic [TIME_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_FADE = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [GAIN_W-1:0]   gain_reg;
    logic [TIME_W-1:0]   fade_time_reg;
    logic [LEVEL_W-1:0]  target_reg;
    logic [LEVEL_W-1:0]  applied_reg;
    logic [LEVEL_W-1:0]  remembered_reg;
    logic [TIME_W-1:0]   period_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    in_word_t            item_reg;
    out_word_t           result_reg;
    logic                result_valid_reg;

    logic signed [14:0]  delta;
    logic signed [14:0]  sum;
    logic [LEVEL_W-1:0]  sat_level;
    logic [LEVEL_W-1:0]  calc_level;
    logic                user;
    logic                take_item;
    logic                out_free;
    logic [15:0]         square;
    div_ctl_t            div_ctl;
    logic [TIME_W-1:0]   div_quot;

    assign take_item = item_valid && !item_stall;
    assign out_free  = !result_valid_reg || !result_stall;

    // Level arithmetic for the pass in hand
    always_comb
    begin
        delta = $signed({{7{item_reg.encoder_count[7]}}, item_reg.encoder_count})
              * $signed({9'd0, gain_reg});
        sum   = $signed({7'd0, target_reg}) + delta;
        if (sum < 0)
            sat_level = '0;
        else if (sum > $signed({7'd0, LEVEL_MAX}))
            sat_level = LEVEL_MAX;
        else
            sat_level = sum[LEVEL_W-1:0];

        if (item_reg.button_event)
            calc_level = (applied_reg != '0) ? '0 : remembered_reg;
        else
            calc_level = sat_level;

        user   = (delta != '0) || item_reg.button_event;
        square = {8'd0, applied_reg} * {8'd0, applied_reg};
    end

    // Divider for fade_time / (level + 1)
    assign div_ctl.start = (state_reg == ST_CALC) && user;

    edim_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (fade_time_reg),
        .divisor  ({1'b0, calc_level} + DIVISOR_W'(1)),
        .done     (div_ctl.done),
        .quotient (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (item_valid) state_next = ST_CALC;
            ST_CALC: state_next = user ? ST_DIV : ST_FADE;
            ST_DIV:  if (div_ctl.done) state_next = ST_FADE;
            ST_FADE: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gain_reg         <= GAIN_RESET;
            fade_time_reg    <= FADE_TIME_RESET;
            target_reg       <= '0;
            applied_reg      <= '0;
            remembered_reg   <= REMEMBERED_INIT;
            period_reg       <= FADE_TIME_RESET;
            last_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // config writes
            if (cfg_en)
            begin
                unique case (cfg_index)
                    CFG_STEP_GAIN:    gain_reg      <= cfg_data[GAIN_W-1:0];
                    CFG_FADE_TIME_MS: fade_time_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == ST_CALC)
            begin
                target_reg  <= calc_level;
                applied_reg <= calc_level;
                if (item_reg.button_event && applied_reg != '0)
                    remembered_reg <= applied_reg;
            end

            if (state_reg == ST_DIV && div_ctl.done)
                period_reg <= div_quot;

            // fade step: drop shows on the next pass
            if (state_reg == ST_FADE && elapsed_reg > period_reg)
            begin
                if (applied_reg > 8'd1)
                    target_reg <= applied_reg - LEVEL_W'(1);
                last_reg <= item_reg.now_ms;
            end

            // result register
            if (state_reg == ST_OUT && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_item)
            item_reg <= item;
        if (state_reg == ST_CALC)
            elapsed_reg <= item_reg.now_ms - last_reg;
        if (state_reg == ST_OUT && out_free)
        begin
            result_reg.pwm_compare      <= square[PWM_W+1:2];
            result_reg.brightness_level <= applied_reg;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/edim_chk.sv
// Port-level checker for the encoder dimmer, bound to the top level.
`include "encoder_dimmer_with_auto_fade_defines.svh"

module edim_chk
    import edim_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input in_word_t          item,
    input logic              result_valid,
    input logic              result_stall,
    input out_word_t         result,
    input logic              cfg_en,
    input logic              cfg_index,
    input logic [TIME_W-1:0] cfg_data
);

    logic [15:0] level_sq;
    logic        item_take;
    logic        cfg_seen;

    assign level_sq  = {8'd0, result.brightness_level} * {8'd0, result.brightness_level};
    assign item_take = item_valid && !item_stall;
    assign cfg_seen  = cfg_en && (cfg_index == CFG_STEP_GAIN || cfg_index == CFG_FADE_TIME_MS)
                       && (cfg_data == cfg_data);

    // A stalled result holds
    `EDIM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

    // PWM compare always tracks the shown level
    `EDIM_ASSERT_IMPLY(a_pwm_match, clk, rst_n, result_valid, result.pwm_compare == level_sq[PWM_W+1:2])

    // One pass at a time: busy right after a word is taken
    `EDIM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item_take, item_stall)

    // With no result shown and no config write, none appears in the cycle right after a take
    `EDIM_ASSERT_NEXT(a_no_instant_result, clk, rst_n, item_take && !result_valid && !cfg_seen, !result_valid)

endmodule

bind encoder_dimmer_with_auto_fade edim_chk u_edim_chk (.*);
